// ===== rtl/core/cvsc_pkg.sv =====
// Shared constants and register codes for the CV scaler, clipper and folder.
package cvsc_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_AMOUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_MODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SELECT = 3'd4;

  // Clip mode codes.
  localparam logic [1:0] CLIP_HARD = 2'd0;
  localparam logic [1:0] CLIP_SOFT = 2'd1;
  localparam logic [1:0] CLIP_FOLD = 2'd2;
  localparam logic [1:0] CLIP_NONE = 2'd3;

  // Full-scale range codes; the unused code acts as 10 V.
  localparam logic [1:0] RANGE_10V = 2'd0;
  localparam logic [1:0] RANGE_5V  = 2'd1;
  localparam logic [1:0] RANGE_1V  = 2'd2;

  // Q16 unity and the exp2 polynomial coefficients.
  localparam int ONE_Q16 = 65536;
  localparam int POLY_C3 = 5121;
  localparam int POLY_C2 = 14823;
  localparam int POLY_C1 = 45584;

  // Log2 mantissa format and number of fraction rounds.
  localparam int LOG_MANT_W = 31;
  localparam int LOG_ROUNDS = 16;

  typedef logic [CFG_DATA_W-1:0] gain_t;

endpackage

// ===== rtl/core/cvsc_log2.sv =====
// Pipelined log2 fraction extraction by repeated squaring of a Q1.30 mantissa.
module cvsc_log2 #(
  parameter int SIDE_W = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_v,
  input  logic [cvsc_pkg::LOG_MANT_W-1:0]     in_mant,
  input  logic [SIDE_W-1:0]                   in_side,
  output logic                                out_v,
  output logic [cvsc_pkg::LOG_ROUNDS-1:0]     out_frac,
  output logic [SIDE_W-1:0]                   out_side
);

  localparam int MW = cvsc_pkg::LOG_MANT_W;
  localparam int NR = cvsc_pkg::LOG_ROUNDS;

  logic [NR:0]     v;
  logic [MW-1:0]   mant [NR+1];
  logic [NR-1:0]   frac [NR+1];
  logic [SIDE_W-1:0] sd [NR+1];

  assign v[0]    = in_v;
  assign mant[0] = in_mant;
  assign frac[0] = '0;
  assign sd[0]   = in_side;

  // One squaring round per stage; each round yields one fraction bit.
  for (genvar j = 0; j < NR; j++) begin : g_round
    logic [2*MW-1:0] sq;
    logic [MW:0]     top;

    assign sq  = (2*MW)'(mant[j]) * (2*MW)'(mant[j]);
    assign top = sq[2*MW-1:MW-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else begin
        v[j+1] <= v[j];
      end
    end

    // When the square reaches two, the bit is one and the mantissa is halved.
    always_ff @(posedge clk) begin
      mant[j+1] <= top[MW] ? top[MW:1] : top[MW-1:0];
      frac[j+1] <= {frac[j][NR-2:0], top[MW]};
      sd[j+1]   <= sd[j];
    end
  end

  assign out_v    = v[NR];
  assign out_frac = frac[NR];
  assign out_side = sd[NR];

endmodule

// ===== rtl/core/cvsc_div.sv =====
// Pipelined restoring divider, two quotient bits per stage, remainder and low quotient bits out.
module cvsc_div #(
  parameter int DVD_W  = 40,
  parameter int DVS_W  = 24,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_v,
  input  logic [DVD_W-1:0]  in_dvd,
  input  logic [DVS_W-1:0]  dvs,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_v,
  output logic [DVS_W-1:0]  out_rem,
  output logic [15:0]       out_quo,
  output logic [SIDE_W-1:0] out_side
);

  localparam int NST = (DVD_W + 1) / 2;
  localparam int DWP = 2 * NST;

  logic [NST:0]      v;
  logic [DWP-1:0]    d  [NST+1];
  logic [DVS_W-1:0]  rm [NST+1];
  logic [15:0]       q  [NST+1];
  logic [SIDE_W-1:0] sd [NST+1];

  assign v[0]  = in_v;
  assign d[0]  = DWP'(in_dvd);
  assign rm[0] = '0;
  assign q[0]  = '0;
  assign sd[0] = in_side;

  for (genvar j = 0; j < NST; j++) begin : g_stage
    logic [DWP-1:0]   dn;
    logic [DVS_W-1:0] rn;
    logic [15:0]      qn;

    // Two shift, compare and subtract steps over the next dividend bits.
    always_comb begin : step
      logic [DVS_W:0]   r2;
      logic [DWP-1:0]   dt;
      logic [DVS_W-1:0] rt;
      logic [15:0]      qt;
      dt = d[j];
      rt = rm[j];
      qt = q[j];
      r2 = '0;
      for (int b = 0; b < 2; b++) begin
        r2 = {rt, dt[DWP-1]};
        dt = dt << 1;
        if (r2 >= {1'b0, dvs}) begin
          r2 = r2 - {1'b0, dvs};
          qt = {qt[14:0], 1'b1};
        end else begin
          qt = {qt[14:0], 1'b0};
        end
        rt = r2[DVS_W-1:0];
      end
      dn = dt;
      rn = rt;
      qn = qt;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      d[j+1]  <= dn;
      rm[j+1] <= rn;
      q[j+1]  <= qn;
      sd[j+1] <= sd[j];
    end
  end

  assign out_v    = v[NST];
  assign out_rem  = rm[NST];
  assign out_quo  = q[NST];
  assign out_side = sd[NST] ^ SIDE_W'(d[NST] & '0);

endmodule

// ===== rtl/core/cv_scaler_clipper_folder_top.sv =====
// Top level of the CV scaler, clipper and wavefolder pipeline.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------
//  input     | start / busy           | in_sample
//  result    | done (one-cycle strobe)| out_sample
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word enters per clock; busy is high only during reset, so the rate is one sample per cycle.
// The 16 log2 squaring stages and a two-bit-per-stage divider of
// SAMPLE_BITS+16 dividend bits make up most of the pipeline depth.
// Reset is synchronous, clears the valid bits and sets the configuration registers to defaults.
// The receiver cannot stall, so the pipeline never holds and never drops a word.
module cv_scaler_clipper_folder_top #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  output logic                                done,
  output logic signed [SAMPLE_BITS-1:0]       out_sample,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cvsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cvsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int W    = SAMPLE_BITS;
  localparam int FRAC = W - 5;
  localparam int SW   = W + 4;
  localparam int EW   = $clog2(W);
  localparam int DVDW = W + 16;
  localparam int NST  = (DVDW + 1) / 2;
  localparam int LAT  = 29 + NST;
  localparam int LSW  = 2 + EW + W + 1;
  localparam int DSW  = SW + 1;
  localparam int SOFT_LIM = (1 << FRAC) / 1000;
  localparam int FOLD_LIM = (1 << FRAC) / 10000;
  localparam logic [SW-1:0] ONE_VOLT = SW'(1) << FRAC;
  localparam logic [SW-1:0] HALF     = SW'(1) << (W - 1);

  // Configuration registers and values derived from them.
  cvsc_pkg::gain_t scale_gain;
  cvsc_pkg::gain_t clip_amount;
  logic            power_mode;
  logic [1:0]      clip_mode;
  logic [1:0]      range_select;
  logic [W-1:0]    thr;
  logic            soft_tiny;
  logic            fold_tiny;
  logic [3:0]      fs;
  logic [20:0]     clip_fs;
  logic [W+16:0]   thr_wide;

  // Pipeline registers.
  logic              p1_v, p1_neg;
  logic [W-1:0]      p1_a;
  logic [EW-1:0]     enc;
  logic [W+16:0]     lin_full;
  logic              p2_v, p2_neg, p2_zero;
  logic [W-1:0]      p2_a;
  logic [EW-1:0]     p2_e;
  logic [W:0]        p2_lin;
  logic [EW-1:0]     lz;
  logic [W+30:0]     norm;
  logic              p3_v, p3_neg, p3_zero;
  logic [EW-1:0]     p3_e;
  logic [W:0]        p3_lin;
  logic [cvsc_pkg::LOG_MANT_W-1:0] p3_m;
  logic              lg_v;
  logic [cvsc_pkg::LOG_ROUNDS-1:0] lg_frac;
  logic [LSW-1:0]    lg_side;
  logic              lg_neg, lg_zero;
  logic [EW-1:0]     lg_e;
  logic [W:0]        lg_lin;
  logic [5:0]        em;
  logic signed [21:0] lval;
  logic signed [39:0] prod;
  logic              p4_v, p4_neg, p4_zero;
  logic [W:0]        p4_lin;
  logic signed [39:0] p4_prod;
  logic signed [39:0] prod_adj;
  logic              p5_v, p5_neg, p5_zero;
  logic [W:0]        p5_lin;
  logic signed [7:0] p5_k;
  logic [15:0]       p5_f;
  logic [28:0]       pr1;
  logic              p6_v, p6_neg, p6_zero;
  logic [W:0]        p6_lin;
  logic signed [7:0] p6_k;
  logic [15:0]       p6_f;
  logic [14:0]       p6_t;
  logic [31:0]       pr2;
  logic              p7_v, p7_neg, p7_zero;
  logic [W:0]        p7_lin;
  logic signed [7:0] p7_k;
  logic [15:0]       p7_f;
  logic [16:0]       p7_t;
  logic [32:0]       pr3;
  logic              p8_v, p8_neg, p8_zero;
  logic [W:0]        p8_lin;
  logic signed [7:0] p8_k;
  logic [17:0]       p8_mant;
  logic signed [8:0] sh;
  logic signed [8:0] nsh;
  logic [4:0]        amt;
  logic [32:0]       rnd;
  logic [SW-1:0]     s_pow;
  logic [SW-1:0]     s_sel;
  logic              p9_v, p9_neg;
  logic [SW-1:0]     p9_s;
  logic [DVDW-1:0]   dvd;
  logic              dv_v;
  logic [W-1:0]      dv_rem;
  logic [15:0]       dv_q;
  logic [DSW-1:0]    dv_side;
  logic              dv_neg;
  logic [SW-1:0]     dv_s;
  logic              ge, gt, flip;
  logic [16:0]       r_c;
  logic [SW-1:0]     hard_m, fold_m, mo;
  logic              p10_v, p10_neg, p10_soft;
  logic [16:0]       p10_r;
  logic [32:0]       p10_rr;
  logic [SW-1:0]     p10_mo;
  logic [33:0]       cub;
  logic [50:0]       cprod;
  logic              p11_v, p11_neg, p11_soft;
  logic [26:0]       p11_q;
  logic [SW-1:0]     p11_mo;
  logic [W+26:0]     tq;
  logic [SW-1:0]     soft_m;
  logic              p12_v, p12_neg;
  logic [SW-1:0]     p12_m;
  logic [SW-1:0]     msat;
  logic [W-1:0]      ms;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_gain   <= cvsc_pkg::gain_t'(cvsc_pkg::ONE_Q16);
      clip_amount  <= '0;
      power_mode   <= 1'b0;
      clip_mode    <= cvsc_pkg::CLIP_HARD;
      range_select <= cvsc_pkg::RANGE_10V;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cvsc_pkg::REG_SCALE_GAIN:   scale_gain   <= cfg_data;
        cvsc_pkg::REG_CLIP_AMOUNT:  clip_amount  <= cfg_data;
        cvsc_pkg::REG_POWER_MODE:   power_mode   <= cfg_data[0];
        cvsc_pkg::REG_CLIP_MODE:    clip_mode    <= cfg_data[1:0];
        cvsc_pkg::REG_RANGE_SELECT: range_select <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Threshold is the clip fraction times full scale, in sample units.
  always_comb begin
    case (range_select)
      cvsc_pkg::RANGE_5V: fs = 4'd5;
      cvsc_pkg::RANGE_1V: fs = 4'd1;
      default:            fs = 4'd10;
    endcase
    clip_fs  = 21'(clip_amount) * 21'(fs);
    thr_wide = (W+17)'({clip_fs, {FRAC{1'b0}}}) + (W+17)'(32768);
  end

  always_ff @(posedge clk) begin
    thr       <= thr_wide[W+15:16];
    soft_tiny <= (thr <= W'(SOFT_LIM));
    fold_tiny <= (thr <= W'(FOLD_LIM));
  end

  // Valid bits of the top-level stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v  <= 1'b0;
      p2_v  <= 1'b0;
      p3_v  <= 1'b0;
      p4_v  <= 1'b0;
      p5_v  <= 1'b0;
      p6_v  <= 1'b0;
      p7_v  <= 1'b0;
      p8_v  <= 1'b0;
      p9_v  <= 1'b0;
      p10_v <= 1'b0;
      p11_v <= 1'b0;
      p12_v <= 1'b0;
      done  <= 1'b0;
    end else begin
      p1_v  <= start && !busy;
      p2_v  <= p1_v;
      p3_v  <= p2_v;
      p4_v  <= lg_v;
      p5_v  <= p4_v;
      p6_v  <= p5_v;
      p7_v  <= p6_v;
      p8_v  <= p7_v;
      p9_v  <= p8_v;
      p10_v <= dv_v;
      p11_v <= p10_v;
      p12_v <= p11_v;
      done  <= p12_v;
    end
  end

  // Sign and magnitude of the incoming word.
  always_ff @(posedge clk) begin
    p1_neg <= in_sample[W-1];
    p1_a   <= in_sample[W-1] ? (~in_sample + 1'b1) : in_sample;
  end

  // Top bit index and the linear product.
  always_comb begin
    enc = '0;
    for (int i = 0; i < W; i++) begin
      if (p1_a[i]) enc = EW'(i);
    end
    lin_full = (W+17)'(p1_a) * (W+17)'(scale_gain) + (W+17)'(32768);
  end

  always_ff @(posedge clk) begin
    p2_neg  <= p1_neg;
    p2_zero <= (p1_a == '0);
    p2_a    <= p1_a;
    p2_e    <= enc;
    p2_lin  <= lin_full[W+16:16];
  end

  // Normalize the magnitude to a Q1.30 mantissa.
  assign lz   = EW'(W - 1) - p2_e;
  assign norm = {p2_a << lz, {cvsc_pkg::LOG_MANT_W{1'b0}}};

  always_ff @(posedge clk) begin
    p3_neg  <= p2_neg;
    p3_zero <= p2_zero;
    p3_e    <= p2_e;
    p3_lin  <= p2_lin;
    p3_m    <= norm[W+30 -: cvsc_pkg::LOG_MANT_W];
  end

  cvsc_log2 #(
    .SIDE_W (LSW)
  ) u_log2 (
    .clk      (clk),
    .rst      (rst),
    .in_v     (p3_v),
    .in_mant  (p3_m),
    .in_side  ({p3_neg, p3_zero, p3_e, p3_lin}),
    .out_v    (lg_v),
    .out_frac (lg_frac),
    .out_side (lg_side)
  );

  assign {lg_neg, lg_zero, lg_e, lg_lin} = lg_side;

  // Log2 in Q.16 times the exponent.
  assign em   = 6'(lg_e) - 6'(FRAC);
  assign lval = $signed({em, lg_frac});
  assign prod = lval * $signed({1'b0, scale_gain});

  always_ff @(posedge clk) begin
    p4_neg  <= lg_neg;
    p4_zero <= lg_zero;
    p4_lin  <= lg_lin;
    p4_prod <= prod;
  end

  // Divide by 2^16 toward zero, then split into integer and fraction parts.
  assign prod_adj = p4_prod + $signed({24'd0, {16{p4_prod[39]}}});

  always_ff @(posedge clk) begin
    p5_neg  <= p4_neg;
    p5_zero <= p4_zero;
    p5_lin  <= p4_lin;
    p5_k    <= prod_adj[39:32];
    p5_f    <= prod_adj[31:16];
  end

  // Exp2 polynomial, one Horner step per stage.
  assign pr1 = 29'(cvsc_pkg::POLY_C3) * 29'(p5_f);

  always_ff @(posedge clk) begin
    p6_neg  <= p5_neg;
    p6_zero <= p5_zero;
    p6_lin  <= p5_lin;
    p6_k    <= p5_k;
    p6_f    <= p5_f;
    p6_t    <= 15'(cvsc_pkg::POLY_C2) + 15'(pr1[28:16]);
  end

  assign pr2 = 32'(p6_t) * 32'(p6_f);

  always_ff @(posedge clk) begin
    p7_neg  <= p6_neg;
    p7_zero <= p6_zero;
    p7_lin  <= p6_lin;
    p7_k    <= p6_k;
    p7_f    <= p6_f;
    p7_t    <= 17'(cvsc_pkg::POLY_C1) + 17'(pr2[31:16]);
  end

  assign pr3 = 33'(p7_t) * 33'(p7_f);

  always_ff @(posedge clk) begin
    p8_neg  <= p7_neg;
    p8_zero <= p7_zero;
    p8_lin  <= p7_lin;
    p8_k    <= p7_k;
    p8_mant <= 18'(cvsc_pkg::ONE_Q16) + 18'(pr3[32:16]);
  end

  // Scale the mantissa by the power of two (right shifts round half up) and select the linear or power result.
  always_comb begin
    sh    = 9'(p8_k) + 9'(FRAC - 16);
    nsh   = -sh;
    amt   = (nsh > 9'sd31) ? 5'd31 : nsh[4:0];
    rnd   = (33'(p8_mant) + (33'd1 << (amt - 5'd1))) >> amt;
    if (!sh[8]) begin
      s_pow = SW'(p8_mant) << sh[5:0];
    end else begin
      s_pow = SW'(rnd);
    end
    if (!power_mode) begin
      s_sel = SW'(p8_lin);
    end else if (p8_zero) begin
      s_sel = (scale_gain == '0) ? ONE_VOLT : '0;
    end else begin
      s_sel = s_pow;
    end
  end

  always_ff @(posedge clk) begin
    p9_neg <= p8_neg;
    p9_s   <= s_sel;
  end

  // Soft clip divides s<<16 by the threshold; fold divides the excess.
  assign dvd = (clip_mode == cvsc_pkg::CLIP_SOFT) ? DVDW'({p9_s[W-1:0], 16'h0})
                                                   : DVDW'(p9_s - SW'(thr));

  cvsc_div #(
    .DVD_W  (DVDW),
    .DVS_W  (W),
    .SIDE_W (DSW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_v     (p9_v),
    .in_dvd   (dvd),
    .dvs      (thr),
    .in_side  ({p9_neg, p9_s}),
    .out_v    (dv_v),
    .out_rem  (dv_rem),
    .out_quo  (dv_q),
    .out_side (dv_side)
  );

  assign {dv_neg, dv_s} = dv_side;

  // Hard and fold magnitudes, and the soft-clip ratio squared.
  always_comb begin
    ge     = (dv_s >= SW'(thr));
    gt     = (dv_s > SW'(thr));
    r_c    = ge ? 17'(cvsc_pkg::ONE_Q16) : {1'b0, dv_q};
    hard_m = gt ? SW'(thr) : dv_s;
    flip   = 1'b0;
    if (fold_tiny) begin
      fold_m = '0;
    end else if (gt) begin
      fold_m = SW'(thr) - SW'(dv_rem);
      flip   = dv_q[0];
    end else begin
      fold_m = dv_s;
    end
    case (clip_mode)
      cvsc_pkg::CLIP_HARD: mo = hard_m;
      cvsc_pkg::CLIP_FOLD: mo = fold_m;
      default:             mo = dv_s;
    endcase
  end

  always_ff @(posedge clk) begin
    p10_neg  <= dv_neg ^ ((clip_mode == cvsc_pkg::CLIP_FOLD) && flip);
    p10_soft <= (clip_mode == cvsc_pkg::CLIP_SOFT);
    p10_r    <= r_c;
    p10_rr   <= 33'(r_c) * 33'(r_c);
    p10_mo   <= mo;
  end

  // Cubic 1.5r - 0.5r^3 in Q25.
  assign cub   = 34'(3) * 34'(34'd1 << 32) - 34'(p10_rr);
  assign cprod = 51'(p10_r) * 51'(cub);

  always_ff @(posedge clk) begin
    p11_neg  <= p10_neg;
    p11_soft <= p10_soft;
    p11_mo   <= p10_mo;
    p11_q    <= cprod[50:24];
  end

  // Scale the cubic by the threshold and pick the magnitude.
  assign tq     = (W+27)'(thr) * (W+27)'(p11_q) + (W+27)'(1 << 24);
  assign soft_m = soft_tiny ? '0 : SW'(tq[W+26:25]);

  always_ff @(posedge clk) begin
    p12_neg <= p11_neg;
    p12_m   <= p11_soft ? soft_m : p11_mo;
  end

  // Saturate to the sample range and restore the sign.
  always_comb begin
    if (!p12_neg && (p12_m > HALF - SW'(1))) begin
      msat = HALF - SW'(1);
    end else if (p12_neg && (p12_m > HALF)) begin
      msat = HALF;
    end else begin
      msat = p12_m;
    end
    ms = msat[W-1:0];
  end

  always_ff @(posedge clk) begin
    out_sample <= p12_neg ? (~ms + 1'b1) : ms;
  end

  // Every result word has a matching accepted input word.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result word without a matching input word");

  // Reset empties the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result word right after reset");

  // A positive result never comes out negative after saturation.
  a_pos_sign: assert property (@(posedge clk) disable iff (rst)
    done && !$past(p12_neg) |-> !out_sample[W-1])
    else $error("positive result wrapped negative");

endmodule
